// File: rtl/core/ssde_pkg.sv
// Package: widths, orbital mask and shared types for the S-squared element block.
package ssde_pkg;

  localparam int unsigned ORBITAL_BITS = 64;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned POP_W        = 7;
  localparam int unsigned ELEM_W       = 14;

  localparam logic [MASK_W-1:0] KEEP_MASK = {MASK_W{1'b1}} >> (MASK_W - ORBITAL_BITS);

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [POP_W-1:0]  pop_t;

endpackage

// File: rtl/core/ssde_popcount.sv
// 64-bit population count as a six-level adder tree.
module ssde_popcount
  import ssde_pkg::*;
(
  input  mask_t bits_i,
  output pop_t  count_o
);

  logic [1:0] sum2  [32];
  logic [2:0] sum4  [16];
  logic [3:0] sum8  [8];
  logic [4:0] sum16 [4];
  logic [5:0] sum32 [2];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      sum2[i] = {1'b0, bits_i[2*i]} + {1'b0, bits_i[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      sum4[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      sum8[i] = {1'b0, sum4[2*i]} + {1'b0, sum4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      sum16[i] = {1'b0, sum8[2*i]} + {1'b0, sum8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      sum32[i] = {1'b0, sum16[2*i]} + {1'b0, sum16[2*i+1]};
    end
  end

  assign count_o = {1'b0, sum32[0]} + {1'b0, sum32[1]};

endmodule

// File: rtl/core/spin_squared_determinant_element_top.sv
// Top level: pipelined S-squared matrix element between two determinants.
//
// Usage: drive the four occupation masks with start_i high for one cycle per
// item. busy_o is always low, so an item is taken at every edge where start_i
// is high; a new item may follow in every cycle.
// Results come out on element_quarters_o (four times the matrix element,
// two's complement) with valid_o high for exactly one cycle per item.
// Pipeline: four register stages. Throughput: one item per cycle, in order,
// set by the four-stage pipeline (mask compare, popcount trees and parity,
// square and classify, final sum).
// Reset (rst_ni low, asynchronous) clears all valid bits; items in flight are
// dropped and valid_o stays low until new items reach the end.
// The receiver cannot stall: each result is shown for one cycle only.
// Mask bits at and above ORBITAL_BITS are ignored.
module spin_squared_determinant_element_top
  import ssde_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [63:0]              bra_alpha_i,
  input  logic [63:0]              bra_beta_i,
  input  logic [63:0]              ket_alpha_i,
  input  logic [63:0]              ket_beta_i,
  output logic                     valid_o,
  output logic signed [ELEM_W-1:0] element_quarters_o
);

  typedef struct packed {
    mask_t ba;
    mask_t bb;
    mask_t open_bra;
    mask_t open_ket;
    mask_t bket;
    mask_t ax;
    mask_t bx;
    mask_t to_alpha;
    mask_t to_beta;
    logic  shell_eq;
  } s1_t;

  typedef struct packed {
    pop_t pop_ba;
    pop_t pop_bb;
    pop_t pop_bket;
    pop_t pop_ax;
    pop_t pop_bx;
    pop_t pop_ta;
    pop_t pop_tb;
    logic neg;
    logic shell_eq;
  } s2_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sq;
    logic signed [ELEM_W-1:0] d2;
    logic signed [ELEM_W-1:0] nb4;
    logic                     diag;
    logic                     swap;
    logic                     neg;
  } s3_t;

  localparam logic signed [ELEM_W-1:0] PLUS_ONE  = ELEM_W'(4);
  localparam logic signed [ELEM_W-1:0] MINUS_ONE = -ELEM_W'(4);

  logic s1_valid_q, s2_valid_q, s3_valid_q, valid_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic signed [ELEM_W-1:0] elem_d, elem_q;
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // stage 1: shell masks and exchange masks
  mask_t ba, bb, ka, kb, ob, ok, cb, ck, abra, bbra, aket;
  always_comb begin
    ba   = bra_alpha_i & KEEP_MASK;
    bb   = bra_beta_i  & KEEP_MASK;
    ka   = ket_alpha_i & KEEP_MASK;
    kb   = ket_beta_i  & KEEP_MASK;
    ob   = ba ^ bb;
    ok   = ka ^ kb;
    cb   = ba & bb;
    ck   = ka & kb;
    abra = ba & ob;
    bbra = bb & ob;
    aket = ka & ok;
    s1_d.ba       = ba;
    s1_d.bb       = bb;
    s1_d.open_bra = ob;
    s1_d.open_ket = ok;
    s1_d.bket     = kb & ok;
    s1_d.ax       = abra ^ aket;
    s1_d.bx       = bbra ^ (kb & ok);
    s1_d.to_alpha = (abra ^ aket) & bbra;
    s1_d.to_beta  = (abra ^ aket) & abra;
    s1_d.shell_eq = (ob == ok) && (cb == ck);
  end

  // stage 2: popcounts and swap phase
  pop_t pop_ba, pop_bb, pop_bket, pop_ax, pop_bx, pop_ta, pop_tb;

  ssde_popcount u_pop_ba   (.bits_i(s1_q.ba),       .count_o(pop_ba));
  ssde_popcount u_pop_bb   (.bits_i(s1_q.bb),       .count_o(pop_bb));
  ssde_popcount u_pop_bket (.bits_i(s1_q.bket),     .count_o(pop_bket));
  ssde_popcount u_pop_ax   (.bits_i(s1_q.ax),       .count_o(pop_ax));
  ssde_popcount u_pop_bx   (.bits_i(s1_q.bx),       .count_o(pop_bx));
  ssde_popcount u_pop_ta   (.bits_i(s1_q.to_alpha), .count_o(pop_ta));
  ssde_popcount u_pop_tb   (.bits_i(s1_q.to_beta),  .count_o(pop_tb));

  // parity of a and b below a one-hot index equals parity of (a ^ b) below it
  always_comb begin
    s2_d.pop_ba   = pop_ba;
    s2_d.pop_bb   = pop_bb;
    s2_d.pop_bket = pop_bket;
    s2_d.pop_ax   = pop_ax;
    s2_d.pop_bx   = pop_bx;
    s2_d.pop_ta   = pop_ta;
    s2_d.pop_tb   = pop_tb;
    s2_d.neg = (^(s1_q.open_bra & (s1_q.to_alpha - MASK_W'(1))))
             ^ (^(s1_q.open_ket & (s1_q.to_beta  - MASK_W'(1))));
    s2_d.shell_eq = s1_q.shell_eq;
  end

  // stage 3: spin difference square and classification
  logic signed [POP_W:0]     d;
  logic signed [2*POP_W+1:0] sq_full;
  logic [POP_W:0]            nexch;
  always_comb begin
    d       = $signed({1'b0, s2_q.pop_ba}) - $signed({1'b0, s2_q.pop_bb});
    sq_full = d * d;
    nexch   = {1'b0, s2_q.pop_ax} + {1'b0, s2_q.pop_bx};
    s3_d.sq   = sq_full[ELEM_W-1:0];
    s3_d.d2   = ELEM_W'(d) <<< 1;
    s3_d.nb4  = $signed({{(ELEM_W-POP_W-2){1'b0}}, s2_q.pop_bket, 2'b00});
    s3_d.diag = s2_q.shell_eq && (nexch == '0);
    s3_d.swap = s2_q.shell_eq && (nexch == (POP_W+1)'(4))
             && (s2_q.pop_ta == POP_W'(1)) && (s2_q.pop_tb == POP_W'(1));
    s3_d.neg  = s2_q.neg;
  end

  // stage 4: final value
  always_comb begin
    if (s3_q.diag) begin
      elem_d = s3_q.sq + s3_q.d2 + s3_q.nb4;
    end else if (s3_q.swap) begin
      elem_d = s3_q.neg ? MINUS_ONE : PLUS_ONE;
    end else begin
      elem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      valid_q    <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s2_valid_q) begin
      s3_q <= s3_d;
    end
    if (s3_valid_q) begin
      elem_q <= elem_d;
    end
  end

  assign valid_o            = valid_q;
  assign element_quarters_o = elem_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (element_quarters_o >= MINUS_ONE && element_quarters_o <= ELEM_W'(4480)))
    else $error("element out of range");

  a_neg_only_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && element_quarters_o < 0) |-> element_quarters_o == MINUS_ONE)
    else $error("negative element other than minus one");

  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> !(s3_q.diag && s3_q.swap))
    else $error("item classified both diagonal and swap");

endmodule
